>>> rtl/rsi_pkg.sv
package rsi_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam int unsigned CHAR_W  = 16;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 6;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEXMAX = 6'd33;

  localparam logic [CHAR_W-1:0] CH_NUL   = 16'h0000;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;
  localparam logic [CHAR_W-1:0] CH_UA    = 16'h0041;
  localparam logic [CHAR_W-1:0] CH_UZ    = 16'h005A;
  localparam logic [CHAR_W-1:0] CH_LA    = 16'h0061;
  localparam logic [CHAR_W-1:0] CH_LZ    = 16'h007A;
  localparam logic [CHAR_W-1:0] CH_LX    = 16'h0078;
  localparam logic [CHAR_W-1:0] CH_UX    = 16'h0058;
  localparam logic [CHAR_W-1:0] CH_MINUS = 16'h002D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 16'h002B;

  typedef enum logic {
    REG_RADIX  = 1'b0,
    REG_SIGNED = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_FROZEN = 2'd2
  } phase_t;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               signed_mode;
  } cfg_t;

  typedef struct packed {
    logic               term;
    logic               space;
    logic               minus;
    logic               plus;
    logic               zero_pfx;
    logic               is_x;
    logic               dig_ok;
    logic [DIGIT_W-1:0] digit;
  } cls_t;

  typedef struct packed {
    logic pop;
    logic term_pop;
  } back_stat_t;

endpackage

>>> rtl/rsi_front.sv
module rsi_front (
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rsi_pkg::CHAR_W-1:0]        in_char_code,
  input  rsi_pkg::cfg_t                     cfg,
  input  logic                              q_full,
  output logic                              push,
  output rsi_pkg::cls_t                     push_cls
);

  logic [rsi_pkg::CHAR_W-1:0]  c;
  logic                        is_num;
  logic                        is_up;
  logic                        is_lo;
  logic [rsi_pkg::CHAR_W-1:0]  dig_wide;

  assign c        = in_char_code;
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    is_num = (c >= rsi_pkg::CH_ZERO) && (c <= rsi_pkg::CH_NINE);
    is_up  = (c >= rsi_pkg::CH_UA) && (c <= rsi_pkg::CH_UZ);
    is_lo  = (c >= rsi_pkg::CH_LA) && (c <= rsi_pkg::CH_LZ);
    if (is_num) begin
      dig_wide = c - rsi_pkg::CH_ZERO;
    end else if (is_up) begin
      dig_wide = c - rsi_pkg::CH_UA + 16'd10;
    end else begin
      dig_wide = c - rsi_pkg::CH_LA + 16'd10;
    end

    push_cls.term  = (c == rsi_pkg::CH_NUL);
    push_cls.space = ((c >= 16'h0009) && (c <= 16'h000D)) ||
                     ((c >= 16'h001C) && (c <= 16'h0020)) ||
                     (c == 16'h1680) ||
                     ((c >= 16'h2000) && (c <= 16'h2006)) ||
                     ((c >= 16'h2008) && (c <= 16'h200A)) ||
                     (c == 16'h2028) || (c == 16'h2029) ||
                     (c == 16'h205F) || (c == 16'h3000);
    push_cls.minus = (c == rsi_pkg::CH_MINUS);
    push_cls.plus  = (c == rsi_pkg::CH_PLUS);
    push_cls.zero_pfx = (c == rsi_pkg::CH_ZERO) && !cfg.signed_mode &&
                        (cfg.radix > rsi_pkg::RADIX_DEC) &&
                        (cfg.radix <= rsi_pkg::RADIX_HEXMAX);
    push_cls.is_x  = (c == rsi_pkg::CH_LX) || (c == rsi_pkg::CH_UX);
    push_cls.digit = dig_wide[rsi_pkg::DIGIT_W-1:0];
    push_cls.dig_ok = (is_num || is_up || is_lo) &&
                      (dig_wide[rsi_pkg::DIGIT_W-1:0] < cfg.radix);
  end

endmodule

>>> rtl/rsi_queue.sv
module rsi_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rsi_pkg::cls_t        push_cls,
  input  logic                 pop,
  output rsi_pkg::cls_t        head_cls,
  output logic                 empty,
  output logic                 full,
  output logic [rsi_pkg::QAW:0] count
);

  rsi_pkg::cls_t               mem_r [rsi_pkg::QDEPTH];
  logic [rsi_pkg::QAW-1:0]     wptr_r;
  logic [rsi_pkg::QAW-1:0]     wptr_nxt;
  logic [rsi_pkg::QAW-1:0]     rptr_r;
  logic [rsi_pkg::QAW-1:0]     rptr_nxt;
  logic [rsi_pkg::QAW:0]       count_r;
  logic [rsi_pkg::QAW:0]       count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == (rsi_pkg::QAW+1)'(rsi_pkg::QDEPTH));
  assign count    = count_r;
  assign head_cls = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r + (rsi_pkg::QAW+1)'(push) - (rsi_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cls;
    end
  end

endmodule

>>> rtl/rsi_back.sv
module rsi_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rsi_pkg::cfg_t                 cfg,
  input  logic                          q_empty,
  input  rsi_pkg::cls_t                 head_cls,
  output logic                          pop,
  output rsi_pkg::back_stat_t           stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rsi_pkg::VALUE_W-1:0]   out_value
);

  rsi_pkg::phase_t              phase_r;
  rsi_pkg::phase_t              phase_nxt;
  logic [rsi_pkg::VALUE_W-1:0]  acc_r;
  logic [rsi_pkg::VALUE_W-1:0]  acc_nxt;
  logic                         neg_r;
  logic                         neg_nxt;
  logic                         lz_r;
  logic                         lz_nxt;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [rsi_pkg::VALUE_W-1:0]  out_value_r;
  logic [rsi_pkg::VALUE_W-1:0]  out_value_nxt;
  logic [rsi_pkg::VALUE_W-1:0]  mac;
  logic [rsi_pkg::VALUE_W-1:0]  result;
  logic                         take;
  logic                         term_pop;

  assign pop = !q_empty && (!head_cls.term || !out_valid_r || !out_stall);
  assign term_pop      = pop && head_cls.term;
  assign stat.pop      = pop;
  assign stat.term_pop = term_pop;
  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;

  assign mac = acc_r * rsi_pkg::VALUE_W'(cfg.radix) + rsi_pkg::VALUE_W'(head_cls.digit);

  always_comb begin
    take = 1'b0;
    unique case (phase_r)
      rsi_pkg::PH_SPACE: begin
        take = !head_cls.space &&
               !(cfg.signed_mode && (head_cls.minus || head_cls.plus)) &&
               !head_cls.zero_pfx;
      end
      rsi_pkg::PH_DIGITS: begin
        take = !(lz_r && head_cls.is_x);
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    if (pop) begin
      if (head_cls.term) begin
        phase_nxt = rsi_pkg::PH_SPACE;
      end else if (take) begin
        phase_nxt = head_cls.dig_ok ? rsi_pkg::PH_DIGITS : rsi_pkg::PH_FROZEN;
      end else if (phase_r == rsi_pkg::PH_SPACE && !head_cls.space) begin
        phase_nxt = rsi_pkg::PH_DIGITS;
      end
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    lz_nxt  = lz_r;
    result  = acc_r;
    if (cfg.signed_mode && neg_r) begin
      result = '0 - acc_r;
    end
    if (cfg.radix < rsi_pkg::RADIX_MIN || cfg.radix > rsi_pkg::RADIX_MAX) begin
      result = '0;
    end
    out_value_nxt = term_pop ? result : out_value_r;
    out_valid_nxt = term_pop || (out_valid_r && out_stall);
    if (pop) begin
      if (head_cls.term) begin
        acc_nxt = '0;
        neg_nxt = 1'b0;
        lz_nxt  = 1'b0;
      end else begin
        if (phase_r == rsi_pkg::PH_DIGITS) begin
          lz_nxt = 1'b0;
        end
        if (phase_r == rsi_pkg::PH_SPACE && !head_cls.space) begin
          if (cfg.signed_mode && head_cls.minus) begin
            neg_nxt = 1'b1;
          end else if (!cfg.signed_mode && head_cls.zero_pfx) begin
            lz_nxt = 1'b1;
          end
        end
        if (take && head_cls.dig_ok) begin
          acc_nxt = mac;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= rsi_pkg::PH_SPACE;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      lz_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      lz_r        <= lz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
  end

endmodule

>>> rtl/radix_string_to_integer_unit.sv
// Parses a stream of UTF-16 code units, one per beat, into a 64-bit integer in the base
// held in the radix register, and returns one result beat for every terminating zero code
// unit. A code unit is taken every cycle unless the queue is full: the front part
// classifies it and writes it into a four-entry queue in the same cycle, and the back
// part retires one entry per cycle unless the queue is empty or a terminator is held,
// with a single 64-bit by 6-bit multiply-accumulate, which sets the rate of one code
// unit per clock. A result is registered as its terminator leaves the queue, and a
// terminator waits there while the output register still holds an untaken result.
// Configuration writes are always accepted and should be made while no string is in flight.
module radix_string_to_integer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rsi_pkg::CHAR_W-1:0]       in_char_code,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rsi_pkg::VALUE_W-1:0]      out_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [rsi_pkg::RADIX_W-1:0]      cfg_data
);

  rsi_pkg::cfg_t              cfg_r;
  rsi_pkg::cfg_t              cfg_nxt;
  logic                       push;
  rsi_pkg::cls_t              push_cls;
  rsi_pkg::cls_t              head_cls;
  logic                       q_empty;
  logic                       q_full;
  logic [rsi_pkg::QAW:0]      q_count;
  logic                       pop;
  rsi_pkg::back_stat_t        stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (rsi_pkg::reg_idx_t'(cfg_index))
        rsi_pkg::REG_RADIX:  cfg_nxt.radix = cfg_data;
        rsi_pkg::REG_SIGNED: cfg_nxt.signed_mode = cfg_data[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radix       <= rsi_pkg::RADIX_RESET;
      cfg_r.signed_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rsi_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .cfg          (cfg_r),
    .q_full       (q_full),
    .push         (push),
    .push_cls     (push_cls)
  );

  rsi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cls (push_cls),
    .pop      (pop),
    .head_cls (head_cls),
    .empty    (q_empty),
    .full     (q_full),
    .count    (q_count)
  );

  rsi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .head_cls  (head_cls),
    .pop       (pop),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pop |-> q_count != '0)
    else $error("queue popped while empty");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_count != (rsi_pkg::QAW+1)'(rsi_pkg::QDEPTH))
    else $error("queue written while full");

  a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
    stat.term_pop |=> out_valid)
    else $error("terminator retired without a result beat");

  a_term_slot: assert property (@(posedge clk) disable iff (!rst_n)
    stat.term_pop |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

endmodule

>>> bench/tb_radix_string_to_integer_unit.sv
module tb_radix_string_to_integer_unit;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 80;
  localparam int N_DIRECTED    = 34;
  localparam int N_PHASES      = 16;
  localparam int PHASE_CHARS   = 95;

  typedef enum logic [1:0] {
    ROW_CHAR   = 2'd0,
    ROW_RADIX  = 2'd1,
    ROW_SIGNED = 2'd2
  } row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [rsi_pkg::CHAR_W-1:0]  code;
    logic                        typed;
    logic [rsi_pkg::VALUE_W-1:0] value;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [rsi_pkg::CHAR_W-1:0] in_char_code;
  logic out_valid;
  logic out_stall;
  logic [rsi_pkg::VALUE_W-1:0] out_value;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [rsi_pkg::RADIX_W-1:0] cfg_data;

  logic [rsi_pkg::RADIX_W-1:0] cfg_radix;
  logic                        cfg_signed;
  rsi_pkg::phase_t             parse_phase;
  logic [rsi_pkg::VALUE_W-1:0] acc_value;
  logic                        neg_seen;
  logic                        zero_pending;

  logic [rsi_pkg::VALUE_W-1:0] pending_values[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned chars_sent = 0;
  bit row_is_typed = 1'b0;
  logic [rsi_pkg::VALUE_W-1:0] typed_value = '0;
  bit long_hold_req = 1'b0;
  int in_gap_mode = 1;
  int out_gap_mode = 1;

  logic [rsi_pkg::CHAR_W-1:0] space_codes [23] = '{
    16'h0009, 16'h000A, 16'h000B, 16'h000C, 16'h000D, 16'h001C, 16'h001D, 16'h001E,
    16'h001F, 16'h0020, 16'h1680, 16'h2000, 16'h2003, 16'h2006, 16'h2008, 16'h200A,
    16'h2028, 16'h2029, 16'h205F, 16'h3000, 16'h00A0, 16'h2007, 16'h202F
  };

  logic [rsi_pkg::RADIX_W-1:0] radix_plan [N_PHASES] = '{
    6'd10, 6'd16, 6'd36, 6'd2, 6'd33, 6'd11, 6'd34, 6'd2,
    6'd36, 6'd8, 6'd1, 6'd0, 6'd63, 6'd37, 6'd12, 6'd35
  };
  logic signed_plan [N_PHASES] = '{
    1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0
  };

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_CHAR,   16'h3000,          1'b0, 64'd0},
    '{ROW_CHAR,   16'h00A0,          1'b0, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_NUL,   1'b1, 64'd0},
    '{ROW_CHAR,   16'h0009,          1'b0, 64'd0},
    '{ROW_CHAR,   16'h0034,          1'b0, 64'd0},
    '{ROW_CHAR,   16'h0032,          1'b0, 64'd0},
    '{ROW_CHAR,   16'hFFFF,          1'b0, 64'd0},
    '{ROW_CHAR,   16'h0037,          1'b0, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_NUL,   1'b1, 64'd42},
    '{ROW_CHAR,   rsi_pkg::CH_MINUS, 1'b0, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_NUL,   1'b1, 64'd0},
    '{ROW_RADIX,  16'd16,            1'b0, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_ZERO,  1'b0, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_LX,    1'b0, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_NUL,   1'b1, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_ZERO,  1'b0, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_UX,    1'b0, 64'd0},
    '{ROW_CHAR,   16'h0066,          1'b0, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_NUL,   1'b1, 64'd15},
    '{ROW_SIGNED, 16'd1,             1'b0, 64'd0},
    '{ROW_RADIX,  16'd36,            1'b0, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_MINUS, 1'b0, 64'd0},
    '{ROW_CHAR,   16'h0031,          1'b0, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_NUL,   1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{ROW_CHAR,   rsi_pkg::CH_PLUS,  1'b0, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_LZ,    1'b0, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_NUL,   1'b1, 64'd35},
    '{ROW_RADIX,  16'd0,             1'b0, 64'd0},
    '{ROW_CHAR,   16'h0031,          1'b0, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_NUL,   1'b1, 64'd0},
    '{ROW_RADIX,  16'd63,            1'b0, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_UZ,    1'b0, 64'd0},
    '{ROW_CHAR,   rsi_pkg::CH_NUL,   1'b1, 64'd0},
    '{ROW_SIGNED, 16'd0,             1'b0, 64'd0}
  };

  radix_string_to_integer_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_radix_string_to_integer_unit: done, errors");
      $finish;
    end
  end

  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 16);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  task automatic parse_step(input logic [rsi_pkg::CHAR_W-1:0] c, output bit emit,
                            output logic [rsi_pkg::VALUE_W-1:0] result);
    int dv;
    bit ws;
    bit take;
    begin
      emit = 1'b0;
      result = '0;
      take = 1'b0;
      ws = (c >= 16'h0009 && c <= 16'h000D) || (c >= 16'h001C && c <= 16'h0020) ||
           c == 16'h1680 || (c >= 16'h2000 && c <= 16'h2006) ||
           (c >= 16'h2008 && c <= 16'h200A) || c == 16'h2028 || c == 16'h2029 ||
           c == 16'h205F || c == 16'h3000;
      if (c >= rsi_pkg::CH_ZERO && c <= rsi_pkg::CH_NINE)
        dv = int'(c - rsi_pkg::CH_ZERO);
      else if (c >= rsi_pkg::CH_UA && c <= rsi_pkg::CH_UZ)
        dv = int'(c - rsi_pkg::CH_UA) + 10;
      else if (c >= rsi_pkg::CH_LA && c <= rsi_pkg::CH_LZ)
        dv = int'(c - rsi_pkg::CH_LA) + 10;
      else dv = 99;

      if (c == rsi_pkg::CH_NUL) begin
        result = acc_value;
        if (cfg_signed && neg_seen) result = 64'd0 - acc_value;
        if (cfg_radix < rsi_pkg::RADIX_MIN || cfg_radix > rsi_pkg::RADIX_MAX) result = '0;
        emit = 1'b1;
        parse_phase = rsi_pkg::PH_SPACE;
        acc_value = '0;
        neg_seen = 1'b0;
        zero_pending = 1'b0;
      end else begin
        case (parse_phase)
          rsi_pkg::PH_SPACE: begin
            if (ws) begin
            end else if (cfg_signed && c == rsi_pkg::CH_MINUS) begin
              neg_seen = 1'b1;
              parse_phase = rsi_pkg::PH_DIGITS;
            end else if (cfg_signed && c == rsi_pkg::CH_PLUS) begin
              parse_phase = rsi_pkg::PH_DIGITS;
            end else if (!cfg_signed && c == rsi_pkg::CH_ZERO &&
                         cfg_radix > rsi_pkg::RADIX_DEC &&
                         cfg_radix <= rsi_pkg::RADIX_HEXMAX) begin
              zero_pending = 1'b1;
              parse_phase = rsi_pkg::PH_DIGITS;
            end else begin
              take = 1'b1;
            end
          end
          rsi_pkg::PH_DIGITS: begin
            if (zero_pending) begin
              zero_pending = 1'b0;
              take = !(c == rsi_pkg::CH_LX || c == rsi_pkg::CH_UX);
            end else begin
              take = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (take) begin
          if (dv < int'(cfg_radix)) begin
            acc_value = acc_value * 64'(cfg_radix) + 64'(dv);
            parse_phase = rsi_pkg::PH_DIGITS;
          end else begin
            parse_phase = rsi_pkg::PH_FROZEN;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    bit emit;
    logic [rsi_pkg::VALUE_W-1:0] predicted;
    logic [rsi_pkg::VALUE_W-1:0] want;
    if (!rst_n) begin
      cfg_radix = rsi_pkg::RADIX_RESET;
      cfg_signed = 1'b0;
      parse_phase = rsi_pkg::PH_SPACE;
      acc_value = '0;
      neg_seen = 1'b0;
      zero_pending = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rsi_pkg::REG_RADIX) cfg_radix = cfg_data;
        else cfg_signed = cfg_data[0];
      end
      if (in_valid && !in_stall) begin
        parse_step(in_char_code, emit, predicted);
        if (emit) pending_values.push_back(row_is_typed ? typed_value : predicted);
      end
      if (out_valid && !out_stall) begin
        if (pending_values.size() == 0) begin
          $display("%0t: result beat with none expected, got %h", $time, out_value);
          fail_count++;
        end else begin
          want = pending_values.pop_front();
          if (out_value !== want) begin
            $display("%0t: value mismatch, expected %h, got %h", $time, want, out_value);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int w;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        w = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        w = draw_gap(out_gap_mode);
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_char(input logic [rsi_pkg::CHAR_W-1:0] c);
    int gap;
    begin
      gap = draw_gap(in_gap_mode);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_char_code <= c;
      do @(posedge clk); while (in_stall);
      chars_sent++;
      @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_values.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input rsi_pkg::reg_idx_t idx,
                           input logic [rsi_pkg::RADIX_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_string();
    logic [rsi_pkg::CHAR_W-1:0] text[$];
    int kind;
    int nd;
    int lim;
    int d;
    logic [rsi_pkg::CHAR_W-1:0] letter_base;
    begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 8))
          text.push_back(rsi_pkg::CHAR_W'($urandom_range(0, 65535)));
      end else begin
        repeat ($urandom_range(0, 3)) text.push_back(space_codes[$urandom_range(0, 19)]);
        if (kind == 1) text.push_back(space_codes[$urandom_range(20, 22)]);
        if (cfg_signed && $urandom_range(0, 2) != 0)
          text.push_back($urandom_range(0, 1) ? rsi_pkg::CH_MINUS : rsi_pkg::CH_PLUS);
        if (!cfg_signed && cfg_radix > rsi_pkg::RADIX_DEC &&
            cfg_radix <= rsi_pkg::RADIX_HEXMAX && $urandom_range(0, 1)) begin
          text.push_back(rsi_pkg::CH_ZERO);
          text.push_back($urandom_range(0, 1) ? rsi_pkg::CH_LX : rsi_pkg::CH_UX);
        end
        if (cfg_radix < rsi_pkg::RADIX_MIN) lim = 10;
        else if (cfg_radix > rsi_pkg::RADIX_MAX) lim = 36;
        else lim = int'(cfg_radix);
        nd = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 8);
        for (int i = 0; i < nd + ((kind == 2) ? 3 : 0); i++) begin
          if (kind == 2 && i == nd) begin
            if (lim < 36) d = lim;
            else d = -1;
          end else begin
            d = $urandom_range(0, lim - 1);
          end
          letter_base = $urandom_range(0, 1) ? rsi_pkg::CH_UA : rsi_pkg::CH_LA;
          if (d < 0) text.push_back(16'h002E);
          else if (d < 10) text.push_back(rsi_pkg::CH_ZERO + rsi_pkg::CHAR_W'(d));
          else text.push_back(letter_base + rsi_pkg::CHAR_W'(d - 10));
        end
      end
      text.push_back(rsi_pkg::CH_NUL);
      foreach (text[i]) send_char(text[i]);
    end
  endtask

  initial begin
    int unsigned mark;
    logic [rsi_pkg::RADIX_W-1:0] sdata;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_code = '0;
    cfg_valid = 1'b0;
    cfg_index = rsi_pkg::REG_RADIX;
    cfg_data = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      case (directed_rows[i].kind)
        ROW_RADIX:
          write_reg(rsi_pkg::REG_RADIX, directed_rows[i].code[rsi_pkg::RADIX_W-1:0]);
        ROW_SIGNED:
          write_reg(rsi_pkg::REG_SIGNED, directed_rows[i].code[rsi_pkg::RADIX_W-1:0]);
        default: begin
          row_is_typed = directed_rows[i].typed;
          typed_value = directed_rows[i].value;
          send_char(directed_rows[i].code);
        end
      endcase
    end
    row_is_typed = 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(rsi_pkg::REG_RADIX, radix_plan[p]);
      sdata = {(rsi_pkg::RADIX_W-1)'($urandom_range(0, 31)), signed_plan[p]};
      write_reg(rsi_pkg::REG_SIGNED, sdata);
      in_gap_mode = $urandom_range(0, 2);
      out_gap_mode = $urandom_range(0, 2);
      if (p == 5) begin
        wait_idle();
        in_gap_mode = 0;
        long_hold_req = 1'b1;
        repeat (12) begin
          send_char(16'h0037);
          send_char(rsi_pkg::CH_NUL);
        end
        in_gap_mode = 1;
      end
      mark = chars_sent;
      while (chars_sent - mark < PHASE_CHARS) send_random_string();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb_radix_string_to_integer_unit: done, clean");
    end else begin
      $display("tb_radix_string_to_integer_unit: done, errors");
    end
    $finish;
  end

endmodule
